FILE: rtl/core/xcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcrc_pkg;

	// Packet geometry
	localparam int PAYLOAD_BYTES = 128;
	localparam int PACKET_BYTES  = PAYLOAD_BYTES + 5;
	localparam int IDX_W         = $clog2(PACKET_BYTES + 1);

	localparam logic [IDX_W-1:0] IDX_HEADER = IDX_W'(0);
	localparam logic [IDX_W-1:0] IDX_NUMBER = IDX_W'(1);
	localparam logic [IDX_W-1:0] IDX_COMPL  = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_PAY_LO = IDX_W'(3);
	localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(PAYLOAD_BYTES + 3);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(PACKET_BYTES - 1);

	// Line characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Input actions
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_TIMEOUT     = 2'd0;
	localparam logic [1:0] REG_PKT_RETRIES = 2'd1;
	localparam logic [1:0] REG_START_RETRY = 2'd2;

	localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
	localparam logic [7:0]  PKT_RETRIES_RST = 8'd4;
	localparam logic [7:0]  START_RETRY_RST = 8'd1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_EOTW = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_ACCEPTED  = 4'd1,
		EV_DUPLICATE = 4'd2,
		EV_NOTHING   = 4'd3,
		EV_TIMEOUT   = 4'd4,
		EV_HEADER    = 4'd5,
		EV_NUMBER    = 4'd6,
		EV_CRC       = 4'd7,
		EV_EOT       = 4'd8,
		EV_DONE      = 4'd9,
		EV_FAILED    = 4'd10
	} ev_t;

	// CRC-16, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
	                                           input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/xmodem_crc_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// XMODEM-CRC receiver, 128-byte blocks.
// Input channel (item_valid / item_stall): one word per event, action 0 start,
// 1 received serial byte (rx_byte), 2 timer tick; action 3 is ignored.
// Result channel (res_valid / res_stall): exactly one word per input word,
// carrying the response byte to send ('C', ACK or NAK), a tentative payload
// byte, the event code and the busy flag. Payload bytes stand until the
// packet's verdict: keep them only when that packet ends with "accepted".
// Configuration (cfg_valid / cfg_ready): timeout, packet retries and start
// retries; write only while no word is in flight.
// A word accepted into the input register is judged by the state logic as it
// advances; its result is registered and shown on the result port until taken.
// Throughput: one word per cycle while res_stall does not hold a full result
// register, set by the combinational byte CRC update and packet checks
// against the state registers.
// Reset clears the transfer (idle, expected block 1) and loads the register
// defaults: 1000 ticks, 4 packet retries, 1 start retry.
// When res_stall holds a full result register, the input register keeps its
// word and item_stall rises; nothing is dropped.
module xmodem_crc_receiver
	import xcrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input words
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [1:0] action,
	input  wire logic [7:0] rx_byte,
	// result words
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            tx_valid,
	output logic [7:0]      tx_byte,
	output logic            data_valid,
	output logic [7:0]      data_byte,
	output logic [3:0]      event_res,
	output logic            busy_res,
	// configuration
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [15:0] timeout_q;
	logic [7:0]  pkt_retries_q;
	logic [7:0]  start_retries_q;

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [1:0] action_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       item_acc;

	// ---------------------------------------------------------------
	// Transfer state
	// ---------------------------------------------------------------
	phase_t            phase_q, n_phase;
	logic [IDX_W-1:0]  idx_q, n_idx;
	logic [15:0]       tick_q, n_tick;
	logic [7:0]        att_q, n_att;
	logic [7:0]        exp_q, n_exp;
	logic              fack_q, n_fack;
	logic [15:0]       crc_q, n_crc;
	logic [7:0]        header_q, n_header;
	logic [7:0]        num_q, n_num;
	logic [7:0]        cpl_q, n_cpl;
	logic [7:0]        crc_hi_q, n_crc_hi;

	// result register
	logic       res_valid_q;
	logic       txv_q, n_txv;
	logic [7:0] tx_q, n_tx;
	logic       dv_q, n_dv;
	logic [7:0] db_q, n_db;
	ev_t        ev_q, n_ev;

	// decisions
	logic             is_start, byte_recv, eot_hit, byte_fin, tick_in, tick_to;
	logic             fin, na, na_fail, eot_fail, eotw_to;
	logic [15:0]      tick_sat;
	logic [IDX_W-1:0] idx_inc;
	ev_t              judge_code, fin_code;
	logic [7:0]       att_fin, att_na, eot_att;
	logic             fack_na;

	// handshakes: the input register frees whenever the result register can take
	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !advance;
	assign item_acc   = item_valid && !item_stall;
	assign cfg_ready  = !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q       <= TIMEOUT_RST;
			pkt_retries_q   <= PKT_RETRIES_RST;
			start_retries_q <= START_RETRY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMEOUT:     timeout_q       <= cfg_data;
				REG_PKT_RETRIES: pkt_retries_q   <= cfg_data[7:0];
				REG_START_RETRY: start_retries_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			action_s1 <= action;
			byte_s1   <= rx_byte;
		end
	end

	// ---------------------------------------------------------------
	// Decisions for the word in the input register
	// ---------------------------------------------------------------
	always_comb begin
		is_start  = (action_s1 == ACT_START);
		byte_recv = (action_s1 == ACT_BYTE) && (phase_q == PH_RECV);
		eot_hit   = (action_s1 == ACT_BYTE) && (byte_s1 == CH_EOT) &&
		            ((phase_q == PH_RECV && idx_q == IDX_HEADER) || phase_q == PH_EOTW);
		idx_inc   = idx_q + IDX_W'(1);
		byte_fin  = byte_recv && !eot_hit && (idx_q == IDX_LAST);
		tick_in   = (action_s1 == ACT_TICK) && (phase_q != PH_IDLE);
		tick_sat  = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
		tick_to   = tick_in && (tick_sat >= timeout_q);
		eotw_to   = tick_to && (phase_q == PH_EOTW);

		// packet checks, in order: header, complement, duplicate, sequence, CRC
		if (header_q != CH_SOH) begin
			judge_code = EV_HEADER;
		end else if ((num_q ^ cpl_q) != 8'hFF) begin
			judge_code = EV_NUMBER;
		end else if (fack_q && num_q == exp_q - 8'd1) begin
			judge_code = EV_DUPLICATE;
		end else if (num_q != exp_q) begin
			judge_code = EV_NUMBER;
		end else if (crc_hi_q != crc_q[15:8] || byte_s1 != crc_q[7:0]) begin
			judge_code = EV_CRC;
		end else begin
			judge_code = EV_ACCEPTED;
		end

		fin = byte_fin || (tick_to && phase_q == PH_RECV);
		if (byte_fin) begin
			fin_code = judge_code;
		end else if (idx_q == IDX_HEADER) begin
			fin_code = EV_NOTHING;
		end else if (header_q != CH_SOH) begin
			fin_code = EV_HEADER;
		end else begin
			fin_code = EV_TIMEOUT;
		end

		att_fin  = (fin && fin_code == EV_ACCEPTED) ? pkt_retries_q : att_q;
		na       = is_start || fin;
		att_na   = is_start ? start_retries_q : att_fin;
		fack_na  = is_start ? 1'b0 : (fack_q || (fin && fin_code == EV_ACCEPTED));
		na_fail  = na && (att_na == 8'd0);
		eot_att  = att_q - 8'd1;
		eot_fail = eot_hit && (eot_att == 8'd0);
	end

	// ---------------------------------------------------------------
	// Next phase
	// ---------------------------------------------------------------
	always_comb begin
		n_phase = phase_q;
		if (na) begin
			n_phase = na_fail ? PH_IDLE : PH_RECV;
		end else if (eot_hit) begin
			n_phase = eot_fail ? PH_IDLE : PH_EOTW;
		end else if (eotw_to) begin
			n_phase = PH_IDLE;
		end
	end

	// ---------------------------------------------------------------
	// Datapath and result word
	// ---------------------------------------------------------------
	always_comb begin
		n_idx    = idx_q;
		n_tick   = tick_q;
		n_att    = att_q;
		n_exp    = exp_q;
		n_fack   = fack_q;
		n_crc    = crc_q;
		n_header = header_q;
		n_num    = num_q;
		n_cpl    = cpl_q;
		n_crc_hi = crc_hi_q;
		n_txv    = 1'b0;
		n_tx     = 8'h00;
		n_dv     = 1'b0;
		n_db     = 8'h00;
		n_ev     = EV_NONE;

		// byte collection
		if (byte_recv && !eot_hit) begin
			if (idx_q == IDX_HEADER) begin
				n_tick   = 16'd0;
				n_header = byte_s1;
			end else if (idx_q == IDX_NUMBER) begin
				n_num = byte_s1;
			end else if (idx_q == IDX_COMPL) begin
				n_cpl = byte_s1;
			end else if (idx_q >= IDX_PAY_LO && idx_q < IDX_CRC_HI) begin
				n_crc = crc16_byte(crc_q, byte_s1);
				n_dv  = 1'b1;
				n_db  = byte_s1;
			end else if (idx_q == IDX_CRC_HI) begin
				n_crc_hi = byte_s1;
			end
			n_idx = idx_inc;
		end

		if (tick_in) begin
			n_tick = tick_sat;
		end

		// end of file: ACK each EOT until the count runs out
		if (eot_hit) begin
			n_att = eot_att;
			if (eot_fail) begin
				n_ev = EV_FAILED;
			end else begin
				n_txv  = 1'b1;
				n_tx   = CH_ACK;
				n_tick = 16'd0;
				n_ev   = EV_EOT;
			end
		end

		if (eotw_to) begin
			n_ev = EV_DONE;
		end

		// packet verdict
		if (fin) begin
			n_ev = fin_code;
			if (fin_code == EV_ACCEPTED) begin
				n_txv = 1'b1;
				n_tx  = CH_ACK;
				n_exp = exp_q + 8'd1;
			end else if (fin_code == EV_DUPLICATE) begin
				n_txv = 1'b1;
				n_tx  = CH_ACK;
			end else if (fack_q) begin
				n_txv = 1'b1;
				n_tx  = CH_NAK;
			end
		end

		if (is_start) begin
			n_exp = 8'd1;
		end

		// next attempt, or give up
		if (na) begin
			n_fack = fack_na;
			if (na_fail) begin
				n_att = att_na;
				n_ev  = EV_FAILED;
			end else begin
				n_att  = att_na - 8'd1;
				n_idx  = IDX_HEADER;
				n_tick = 16'd0;
				n_crc  = 16'd0;
				if (!fack_na) begin
					n_txv = 1'b1;
					n_tx  = CH_C;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			idx_q    <= '0;
			tick_q   <= '0;
			att_q    <= '0;
			exp_q    <= 8'd1;
			fack_q   <= 1'b0;
			crc_q    <= '0;
			header_q <= '0;
			num_q    <= '0;
			cpl_q    <= '0;
			crc_hi_q <= '0;
		end else if (advance) begin
			phase_q  <= n_phase;
			idx_q    <= n_idx;
			tick_q   <= n_tick;
			att_q    <= n_att;
			exp_q    <= n_exp;
			fack_q   <= n_fack;
			crc_q    <= n_crc;
			header_q <= n_header;
			num_q    <= n_num;
			cpl_q    <= n_cpl;
			crc_hi_q <= n_crc_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	logic busy_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			txv_q  <= n_txv;
			tx_q   <= n_tx;
			dv_q   <= n_dv;
			db_q   <= n_db;
			ev_q   <= n_ev;
			busy_q <= (n_phase != PH_IDLE);
		end
	end

	assign res_valid  = res_valid_q;
	assign tx_valid   = txv_q;
	assign tx_byte    = tx_q;
	assign data_valid = dv_q;
	assign data_byte  = db_q;
	assign event_res  = ev_q;
	assign busy_res   = busy_q;

endmodule

`default_nettype wire
